// ===== src/ncr_pkg.sv =====
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared constants and the command format that passes from the front end
// to the back end of the character reference decoder.
// ----------------------------------------------------------------------------
package ncr_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int PENDING_DEPTH_MAX = 63;

  // Wide enough to count a full pending buffer of the largest allowed depth.
  localparam int CNT_W = $clog2(PENDING_DEPTH_MAX + 1);

  localparam int QPTR_W      = 2;
  localparam int QUEUE_DEPTH = 1 << QPTR_W;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X    = 8'h78;

  localparam logic [31:0] CP_ONE_MAX   = 32'h0000_0080;
  localparam logic [31:0] CP_TWO_MAX   = 32'h0000_0800;
  localparam logic [31:0] CP_THREE_MAX = 32'h0001_0000;
  localparam logic [31:0] CP_LIMIT     = 32'h0011_0000;

  typedef struct packed {
    logic             hold_en;
    logic [7:0]       ch;
    logic [CNT_W-1:0] hold_idx;
    logic [CNT_W-1:0] flush_cnt;
    logic             flush_first;
    logic [2:0]       emit_n;
    logic             decoded;
    logic [20:0]      cp;
  } ncr_cmd_t;

endpackage

// ===== src/ncr_if.sv =====
// ----------------------------------------------------------------------------
// ncr_if
// Valid/ready channels for the text bytes in and the decoded bytes out.
// ----------------------------------------------------------------------------
interface ncr_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;

  modport source (output valid, ch, is_last, input ready);
  modport sink (input valid, ch, is_last, output ready);
endinterface

interface ncr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       decoded;

  modport source (output valid, out_byte, run_end, decoded, input ready);
  modport sink (input valid, out_byte, run_end, decoded, output ready);
endinterface

// ===== src/ncr_front.sv =====
// ----------------------------------------------------------------------------
// ncr_front
// Scans the text stream one beat per cycle while the queue has room, tracks the
// reference parse and the pending byte count, and issues one command per beat.
// ----------------------------------------------------------------------------
module ncr_front #(
  parameter int PENDING_DEPTH = ncr_pkg::PENDING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ncr_text_if.sink          text,
  input  logic              q_full,
  output logic              push,
  output ncr_pkg::ncr_cmd_t push_cmd
);

  localparam logic [ncr_pkg::CNT_W-1:0] DEPTH_C = ncr_pkg::CNT_W'(PENDING_DEPTH);
  localparam logic [ncr_pkg::CNT_W-1:0] ONE_C   = ncr_pkg::CNT_W'(1);

  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_AMP  = 3'd1,
    PH_HASH = 3'd2,
    PH_DEC  = 3'd3,
    PH_HEX  = 3'd4
  } phase_t;

  phase_t                    phase, phase_next;
  logic [31:0]               code_value, code_next;
  logic [ncr_pkg::CNT_W-1:0] pcnt, pcnt_next;
  ncr_pkg::ncr_cmd_t         cmd;
  logic                      hold_ok;
  logic                      body_hex;
  logic [3:0]                dec_digit;
  logic [3:0]                hex_digit;
  logic [31:0]               code_dec;
  logic [31:0]               code_hex;
  logic [31:0]               code_acc;
  logic [2:0]                utf8_n;
  logic [7:0]                ch;

  assign ch         = text.ch;
  assign text.ready = !q_full;
  assign push       = text.valid && !q_full;
  assign push_cmd   = cmd;

  always_comb begin
    dec_digit = 4'd0;
    hex_digit = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      dec_digit = ch[3:0];
      hex_digit = ch[3:0];
    end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
      hex_digit = ch[3:0] + 4'd9;
    end
    code_dec = {code_value[28:0], 3'b000} + {code_value[30:0], 1'b0} + {28'd0, dec_digit};
    code_hex = {code_value[27:0], hex_digit};
  end

  always_comb begin
    if (code_value < ncr_pkg::CP_ONE_MAX) begin
      utf8_n = 3'd1;
    end else if (code_value < ncr_pkg::CP_TWO_MAX) begin
      utf8_n = 3'd2;
    end else if (code_value < ncr_pkg::CP_THREE_MAX) begin
      utf8_n = 3'd3;
    end else if (code_value < ncr_pkg::CP_LIMIT) begin
      utf8_n = 3'd4;
    end else begin
      utf8_n = 3'd0;
    end
  end

  always_comb begin
    phase_next      = phase;
    code_next       = code_value;
    pcnt_next       = pcnt;
    cmd             = '0;
    cmd.ch          = ch;
    cmd.hold_idx    = pcnt;
    cmd.flush_first = 1'b1;
    hold_ok         = pcnt < DEPTH_C;
    body_hex        = phase == PH_HEX;
    code_acc        = body_hex ? code_hex : code_dec;
    unique case (phase) inside
      PH_AMP: begin
        if (ch == ncr_pkg::CH_HASH) begin
          if (hold_ok) begin
            cmd.hold_en = 1'b1;
            pcnt_next   = pcnt + ONE_C;
          end
          code_next  = '0;
          phase_next = PH_HASH;
        end else if (ch == ncr_pkg::CH_AMP) begin
          cmd.emit_n = 3'd1;
        end else begin
          cmd.flush_cnt = pcnt;
          cmd.emit_n    = 3'd1;
          pcnt_next     = '0;
          phase_next    = PH_TEXT;
        end
      end
      PH_HASH, PH_DEC, PH_HEX: begin
        if (phase == PH_HASH && ch == ncr_pkg::CH_X) begin
          if (hold_ok) begin
            cmd.hold_en = 1'b1;
            pcnt_next   = pcnt + ONE_C;
          end
          phase_next = PH_HEX;
        end else if (ch == ncr_pkg::CH_SEMI) begin
          cmd.emit_n  = utf8_n;
          cmd.decoded = 1'b1;
          cmd.cp      = code_value[20:0];
          pcnt_next   = '0;
          code_next   = '0;
          phase_next  = PH_TEXT;
        end else if (hold_ok) begin
          cmd.hold_en = 1'b1;
          pcnt_next   = pcnt + ONE_C;
          code_next   = code_acc;
          phase_next  = body_hex ? PH_HEX : PH_DEC;
        end else begin
          cmd.flush_cnt = pcnt;
          cmd.emit_n    = 3'd1;
          pcnt_next     = '0;
          code_next     = '0;
          phase_next    = PH_TEXT;
        end
      end
      default: begin
        if (ch == ncr_pkg::CH_AMP) begin
          cmd.hold_en  = 1'b1;
          cmd.hold_idx = '0;
          pcnt_next    = ONE_C;
          phase_next   = PH_AMP;
        end else begin
          cmd.emit_n = 3'd1;
          phase_next = PH_TEXT;
        end
      end
    endcase
    if (text.is_last) begin
      if (pcnt_next != '0) begin
        cmd.flush_cnt   = pcnt_next;
        cmd.flush_first = 1'b0;
      end
      pcnt_next  = '0;
      code_next  = '0;
      phase_next = PH_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      code_value <= '0;
      pcnt       <= '0;
    end else if (push) begin
      phase      <= phase_next;
      code_value <= code_next;
      pcnt       <= pcnt_next;
    end
  end

endmodule

// ===== src/ncr_queue.sv =====
// ----------------------------------------------------------------------------
// ncr_queue
// Small command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ncr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ncr_pkg::ncr_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output ncr_pkg::ncr_cmd_t head,
  output logic              head_valid
);

  localparam logic [ncr_pkg::QPTR_W-1:0] PTR_ONE = ncr_pkg::QPTR_W'(1);
  localparam logic [ncr_pkg::QPTR_W:0]   CNT_ONE = (ncr_pkg::QPTR_W + 1)'(1);

  ncr_pkg::ncr_cmd_t          entries [ncr_pkg::QUEUE_DEPTH];
  logic [ncr_pkg::QPTR_W-1:0] wr_ptr;
  logic [ncr_pkg::QPTR_W-1:0] rd_ptr;
  logic [ncr_pkg::QPTR_W:0]   count;
  logic                       do_push;
  logic                       do_pop;

  assign full       = count == (ncr_pkg::QPTR_W + 1)'(ncr_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count <= count - CNT_ONE;
      end
    end
  end

endmodule

// ===== src/ncr_back.sv =====
// ----------------------------------------------------------------------------
// ncr_back
// Carries out queued commands: writes held bytes into the pending memory,
// replays held text raw, and serializes raw or UTF-8 bytes into the
// output register.
// ----------------------------------------------------------------------------
module ncr_back #(
  parameter int PENDING_DEPTH = ncr_pkg::PENDING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ncr_pkg::ncr_cmd_t head,
  input  logic              head_valid,
  output logic              pop,
  ncr_result_if.source      result
);

  localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam logic [ncr_pkg::CNT_W-1:0] ONE_C = ncr_pkg::CNT_W'(1);

  typedef enum logic [1:0] {
    ST_START,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_OUT
  } state_t;

  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] n, logic [1:0] idx);
    logic [2:0] grp;
    logic [5:0] bits;
    logic [7:0] res;
    grp = n - 3'd1 - {1'b0, idx};
    case (grp)
      3'd0:    bits = cp[5:0];
      3'd1:    bits = cp[11:6];
      3'd2:    bits = cp[17:12];
      default: bits = {3'b000, cp[20:18]};
    endcase
    res = {2'b10, bits};
    if (idx == 2'd0) begin
      case (n)
        3'd1:    res = {1'b0, cp[6:0]};
        3'd2:    res = {3'b110, cp[10:6]};
        3'd3:    res = {4'b1110, cp[15:12]};
        default: res = {5'b11110, cp[20:18]};
      endcase
    end
    return res;
  endfunction

  state_t                    state, state_next;
  logic [ncr_pkg::CNT_W-1:0] fidx, fidx_next;
  logic [1:0]                eidx, eidx_next;
  logic [7:0]                mem [PENDING_DEPTH];
  logic [7:0]                rd_data;
  logic                      mem_we;
  logic                      out_free;
  logic                      load;
  logic [7:0]                ld_byte;
  logic                      ld_end;
  logic                      ld_dec;
  logic [1:0]                eidx_sel;
  logic [7:0]                emit_byte;
  logic                      emit_last;
  logic                      pre_fl;
  logic                      post_fl;
  logic                      fl_last;
  logic                      more_emit;

  assign out_free  = !result.valid || result.ready;
  assign eidx_sel  = (state == ST_START) ? 2'd0 : eidx;
  assign emit_byte = head.decoded ? utf8_byte(head.cp, head.emit_n, eidx_sel) : head.ch;
  assign emit_last = ({1'b0, eidx_sel} + 3'd1) == head.emit_n;
  assign pre_fl    = head.flush_first && head.flush_cnt != '0;
  assign post_fl   = !head.flush_first && head.flush_cnt != '0;
  assign fl_last   = (fidx + ONE_C) == head.flush_cnt;
  assign more_emit = head.flush_first && head.emit_n != 3'd0;

  always_comb begin
    state_next = state;
    fidx_next  = fidx;
    eidx_next  = eidx;
    mem_we     = 1'b0;
    pop        = 1'b0;
    load       = 1'b0;
    ld_byte    = emit_byte;
    ld_end     = emit_last && !post_fl;
    ld_dec     = head.decoded;
    unique case (state)
      ST_START: begin
        if (head_valid) begin
          mem_we    = head.hold_en;
          fidx_next = '0;
          eidx_next = 2'd0;
          if (pre_fl) begin
            state_next = ST_FL_RD;
          end else if (head.emit_n != 3'd0) begin
            if (out_free) begin
              load = 1'b1;
              if (!emit_last) begin
                eidx_next  = 2'd1;
                state_next = ST_EMIT;
              end else if (post_fl) begin
                state_next = ST_FL_RD;
              end else begin
                pop = 1'b1;
              end
            end else begin
              state_next = ST_EMIT;
            end
          end else if (post_fl) begin
            state_next = ST_FL_RD;
          end else begin
            pop = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (!emit_last) begin
            eidx_next = eidx + 2'd1;
          end else if (post_fl) begin
            fidx_next  = '0;
            state_next = ST_FL_RD;
          end else begin
            pop        = 1'b1;
            state_next = ST_START;
          end
        end
      end
      ST_FL_RD: begin
        state_next = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        ld_byte = rd_data;
        ld_end  = fl_last && !more_emit;
        ld_dec  = 1'b0;
        if (out_free) begin
          load = 1'b1;
          if (!fl_last) begin
            fidx_next  = fidx + ONE_C;
            state_next = ST_FL_RD;
          end else if (more_emit) begin
            eidx_next  = 2'd0;
            state_next = ST_EMIT;
          end else begin
            pop        = 1'b1;
            state_next = ST_START;
          end
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.hold_idx[IDX_W-1:0]] <= head.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FL_RD) begin
      rd_data <= mem[fidx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      fidx         <= '0;
      eidx         <= '0;
      result.valid <= 1'b0;
    end else begin
      state <= state_next;
      fidx  <= fidx_next;
      eidx  <= eidx_next;
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
    if (load) begin
      result.out_byte <= ld_byte;
      result.run_end  <= ld_end;
      result.decoded  <= ld_dec;
    end
  end

endmodule

// ===== src/numeric_char_ref_to_utf8_top.sv =====
// ----------------------------------------------------------------------------
// numeric_char_ref_to_utf8_top
// Decodes "&#digits;" and "&#xhex;" references in a byte stream to UTF-8.
//
// The text channel takes one byte per beat, with is_last on the final byte
// of a string. The result channel gives output bytes; run_end marks the
// last byte caused by one input beat, and decoded marks bytes from a
// reference. An input beat that causes no output (held reference text, or
// a code point of 0x110000 or more) gives no result beat.
// The front end accepts a beat per cycle while the four-entry command queue
// has room. An accepted beat's command is registered in the queue, and the
// back end registers its first result byte in the output register when
// nothing is queued ahead of it. Plain bytes and single-byte decodes
// sustain one beat per cycle while the receiver takes them; a multibyte
// decode gives its output bytes one at a time, and a raw replay of held text
// reads each held byte through the registered read of the pending memory.
// When the receiver stalls, the output register holds its beat and the
// queue absorbs up to four commands before text.ready falls. Reset empties
// the queue and output register and returns the parser to plain text.
// ----------------------------------------------------------------------------
module numeric_char_ref_to_utf8_top #(
  parameter int PENDING_DEPTH = ncr_pkg::PENDING_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  ncr_text_if.sink     text,
  ncr_result_if.source result
);

  logic              q_full;
  logic              push;
  ncr_pkg::ncr_cmd_t push_cmd;
  logic              pop;
  ncr_pkg::ncr_cmd_t head;
  logic              head_valid;

  ncr_front #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  ncr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid)
  );

  ncr_back #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== src/ncr_checker.sv =====
// ----------------------------------------------------------------------------
// ncr_checker
// Checks the decoder's ports over time: reset, output stalls and the shape
// of decoded UTF-8 sequences.
// ----------------------------------------------------------------------------
module ncr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_end,
  input logic       decoded
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result beat present right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_end)
      && $stable(decoded))
    else $error("Stalled result beat changed.");

  a_ascii_decode_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && decoded && !out_byte[7] |-> run_end)
    else $error("Single-byte decode not marked as end of run.");

  a_lead_byte_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && decoded && out_byte[7:6] == 2'b11 |-> !run_end && out_byte < 8'hF5)
    else $error("Malformed UTF-8 lead byte.");

endmodule

bind numeric_char_ref_to_utf8_top ncr_checker u_ncr_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .out_byte (result.out_byte),
  .run_end  (result.run_end),
  .decoded  (result.decoded)
);
